[rtl/fttt_pkg.sv]
// Shared types, constants and codes for the flow table TCP tracker.
`default_nettype none
package fttt_pkg;

  localparam int unsigned FlowEntriesDef = 256;

  // l4_kind codes
  localparam logic [1:0] L4_TCP = 2'd1;
  localparam logic [1:0] L4_UDP = 2'd2;
  // ip_version codes
  localparam logic [1:0] IPV_4 = 2'd1;
  localparam logic [1:0] IPV_6 = 2'd2;
  // quic_kind codes
  localparam logic [1:0] QK_LONG  = 2'd1;
  localparam logic [1:0] QK_SHORT = 2'd2;
  // app_label codes
  localparam logic [1:0] LBL_NONE  = 2'd0;
  localparam logic [1:0] LBL_QUIC  = 2'd1;
  localparam logic [1:0] LBL_PROT  = 2'd2;
  localparam logic [1:0] LBL_UDP   = 2'd3;
  // tcp_flags bits
  localparam int unsigned TF_FIN = 0;
  localparam int unsigned TF_SYN = 1;
  localparam int unsigned TF_RST = 2;
  localparam int unsigned TF_ACK = 4;
  // per-flow flag bits
  localparam int unsigned FF_SYN    = 0;
  localparam int unsigned FF_SYNACK = 1;
  localparam int unsigned FF_QUIC   = 2;

  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    STAT_IGNORE = 2'd0,
    STAT_EXIST  = 2'd1,
    STAT_NEW    = 2'd2,
    STAT_FULL   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CS_NONE        = 3'd0,
    CS_SYN_SENT    = 3'd1,
    CS_SYN_RCVD    = 3'd2,
    CS_ESTABLISHED = 3'd3,
    CS_FIN_WAIT    = 3'd4,
    CS_CLOSED      = 3'd5
  } conn_state_e;

  typedef enum logic [1:0] {
    OP_IGNORE = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_PKT    = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    BS_CLEAR = 2'd0,
    BS_IDLE  = 2'd1,
    BS_RD    = 2'd2,
    BS_CMP   = 2'd3
  } back_state_e;

  typedef struct packed {
    logic        cmd;
    logic [1:0]  l4_kind;
    logic [1:0]  ip_version;
    logic [63:0] src_addr_hi;
    logic [63:0] src_addr_lo;
    logic [63:0] dst_addr_hi;
    logic [63:0] dst_addr_lo;
    logic [15:0] src_l4_port;
    logic [15:0] dst_port;
    logic [4:0]  tcp_flags;
    logic [1:0]  quic_kind;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] stream_number;
    logic [2:0]  conn_state;
    logic [31:0] flow_packets;
    logic [1:0]  app_label;
  } out_item_t;

  // canonical flow key: meta is l4_kind, v6 flag, first port, second port
  typedef struct packed {
    logic [34:0] meta;
    logic [63:0] a_hi;
    logic [63:0] a_lo;
    logic [63:0] b_hi;
    logic [63:0] b_lo;
  } key_t;

  localparam int unsigned KeyW = $bits(key_t);

  typedef struct packed {
    op_e        op;
    key_t       key;
    logic [4:0] tcp_flags;
    logic [1:0] quic_kind;
  } qitem_t;

  typedef struct packed {
    logic        valid;
    key_t        key;
    logic [31:0] stream;
    logic [31:0] pkts;
    logic [2:0]  cstate;
    logic [2:0]  flags;
  } ent_t;

  // queue handshake between front and back
  typedef struct packed {
    logic push;
    logic pop;
    logic full;
    logic empty;
  } qctl_t;

endpackage
`default_nettype wire

[rtl/fttt_front.sv]
// Front end: classifies the command and builds the canonical flow key.
`default_nettype none
module fttt_front (
  input  fttt_pkg::in_item_t in_item_i,
  output fttt_pkg::qitem_t   qitem_o
);
  import fttt_pkg::*;

  logic [63:0] a_hi, a_lo, b_hi, b_lo;
  logic [15:0] p1, p2;
  logic        v6, swap, canon;

  function automatic logic [63:0] v4_word(input logic [63:0] a);
    v4_word = {a[7:0], a[15:8], a[23:16], a[31:24], 32'd0};
  endfunction

  always_comb begin
    a_hi = '0;
    a_lo = '0;
    b_hi = '0;
    b_lo = '0;
    v6   = 1'b0;
    canon = 1'b0;
    if (in_item_i.ip_version == IPV_4) begin
      a_hi = v4_word(in_item_i.src_addr_lo);
      b_hi = v4_word(in_item_i.dst_addr_lo);
      canon = 1'b1;
    end else if (in_item_i.ip_version == IPV_6) begin
      a_hi = in_item_i.src_addr_hi;
      a_lo = in_item_i.src_addr_lo;
      b_hi = in_item_i.dst_addr_hi;
      b_lo = in_item_i.dst_addr_lo;
      v6 = 1'b1;
      canon = 1'b1;
    end
    swap = canon &&
           ({a_hi, a_lo, in_item_i.src_l4_port} > {b_hi, b_lo, in_item_i.dst_port});
    p1 = swap ? in_item_i.dst_port : in_item_i.src_l4_port;
    p2 = swap ? in_item_i.src_l4_port : in_item_i.dst_port;

    qitem_o.key.meta = {in_item_i.l4_kind, v6, p1, p2};
    qitem_o.key.a_hi = swap ? b_hi : a_hi;
    qitem_o.key.a_lo = swap ? b_lo : a_lo;
    qitem_o.key.b_hi = swap ? a_hi : b_hi;
    qitem_o.key.b_lo = swap ? a_lo : b_lo;
    qitem_o.tcp_flags = in_item_i.tcp_flags;
    qitem_o.quic_kind = in_item_i.quic_kind;
    if (in_item_i.cmd) begin
      qitem_o.op = OP_CLEAR;
    end else if (in_item_i.l4_kind == L4_TCP || in_item_i.l4_kind == L4_UDP) begin
      qitem_o.op = OP_PKT;
    end else begin
      qitem_o.op = OP_IGNORE;
    end
  end

endmodule
`default_nettype wire

[rtl/fttt_queue.sv]
// Two-entry queue between the front end and the table engine.
`default_nettype none
module fttt_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fttt_pkg::qitem_t wdata_i,
  output fttt_pkg::qitem_t rdata_o,
  input  fttt_pkg::qctl_t  ctl_i,
  output fttt_pkg::qctl_t  stat_o
);
  import fttt_pkg::*;

  qitem_t     mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (ctl_i.push) wp_q <= ~wp_q;
      if (ctl_i.pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, ctl_i.push} - {1'b0, ctl_i.pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) mem_q[wp_q] <= wdata_i;
  end

  assign rdata_o      = mem_q[rp_q];
  assign stat_o.full  = cnt_q == 2'd2;
  assign stat_o.empty = cnt_q == 2'd0;
  assign stat_o.push  = ctl_i.push;
  assign stat_o.pop   = ctl_i.pop;

endmodule
`default_nettype wire

[rtl/fttt_back.sv]
// Table engine: hashed lookup with linear probing, entry update, clear sweep.
`default_nettype none
module fttt_back #(
  parameter int unsigned FLOW_ENTRIES = fttt_pkg::FlowEntriesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fttt_pkg::qitem_t    qitem_i,
  input  logic                q_empty_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output fttt_pkg::out_item_t out_item_o
);
  import fttt_pkg::*;

  localparam int unsigned IW = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
  localparam int unsigned PW = $clog2(FLOW_ENTRIES + 1);
  localparam logic [IW:0]   NumE  = (IW + 1)'(FLOW_ENTRIES);
  localparam logic [IW-1:0] LastE = IW'(FLOW_ENTRIES - 1);
  localparam logic [PW-1:0] NumP  = PW'(FLOW_ENTRIES);

  ent_t        mem [FLOW_ENTRIES];
  ent_t        rdata_q;
  back_state_e state_q, state_d;
  qitem_t      cur_q;
  logic [IW-1:0] addr_q, sweep_q;
  logic [PW-1:0] probes_q;
  logic [31:0]   next_stream_q;
  out_item_t     res_q;
  logic          res_valid_q;

  logic          mem_we;
  logic [IW-1:0] mem_wa;
  ent_t          mem_wd;
  logic [IW-1:0] hash, addr_inc;
  logic [IW-1:0] hfold;
  logic [IW:0]   hwide;
  logic          hit, empty_slot, last_probe;
  logic [31:0]   base_stream, base_pkts, new_pkts;
  logic [2:0]    base_st, new_st, base_fg, new_fg;
  logic [1:0]    label;
  logic          take;

  // XOR fold of the key down to an index, then one correction into range
  always_comb begin
    hfold = '0;
    for (int k = 0; k < KeyW; k++) begin
      hfold[k % IW] = hfold[k % IW] ^ qitem_i.key[k];
    end
    hwide = {1'b0, hfold};
    hash  = (hwide >= NumE) ? IW'(hwide - NumE) : hfold;
  end

  assign addr_inc   = (addr_q == LastE) ? '0 : addr_q + 1'b1;
  assign hit        = rdata_q.valid && (rdata_q.key == cur_q.key);
  assign empty_slot = !rdata_q.valid;
  assign last_probe = (probes_q + 1'b1) == NumP;
  assign take       = !q_empty_i && !res_valid_q;

  // entry update for the packet in hand
  always_comb begin
    base_stream = hit ? rdata_q.stream : next_stream_q;
    base_pkts   = hit ? rdata_q.pkts   : '0;
    base_st     = hit ? rdata_q.cstate : CS_NONE;
    base_fg     = hit ? rdata_q.flags  : '0;
    new_pkts    = (base_pkts == CNT_MAX) ? base_pkts : base_pkts + 32'd1;
    new_st      = base_st;
    new_fg      = base_fg;
    label       = LBL_NONE;
    if (cur_q.key.meta[34:33] == L4_TCP) begin
      if (cur_q.tcp_flags[TF_SYN]) begin
        if (cur_q.tcp_flags[TF_ACK]) begin
          new_fg[FF_SYNACK] = 1'b1;
          if (base_st == CS_SYN_SENT) new_st = CS_SYN_RCVD;
        end else begin
          new_fg[FF_SYN] = 1'b1;
          new_st = CS_SYN_SENT;
        end
      end else if (cur_q.tcp_flags[TF_ACK]) begin
        if (base_fg[FF_SYN] && base_fg[FF_SYNACK] && base_st == CS_SYN_RCVD) begin
          new_st = CS_ESTABLISHED;
        end
      end else if (cur_q.tcp_flags[TF_FIN]) begin
        new_st = CS_FIN_WAIT;
      end else if (cur_q.tcp_flags[TF_RST]) begin
        new_st = CS_CLOSED;
      end
    end else if (cur_q.quic_kind == QK_LONG) begin
      new_fg[FF_QUIC] = 1'b1;
      label = LBL_QUIC;
    end else if (cur_q.quic_kind == QK_SHORT) begin
      label = base_fg[FF_QUIC] ? LBL_PROT : LBL_UDP;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BS_CLEAR: if (sweep_q == LastE) state_d = BS_IDLE;
      BS_IDLE: begin
        if (take) begin
          case (qitem_i.op)
            OP_CLEAR: state_d = BS_CLEAR;
            OP_PKT:   state_d = BS_RD;
            default:  state_d = BS_IDLE;
          endcase
        end
      end
      BS_RD: state_d = BS_CMP;
      BS_CMP: begin
        if (hit || empty_slot || last_probe) state_d = BS_IDLE;
        else state_d = BS_RD;
      end
      default: state_d = BS_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop_o = 1'b0;
    mem_we  = 1'b0;
    mem_wa  = addr_q;
    mem_wd  = '0;
    case (state_q)
      BS_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = sweep_q;
      end
      BS_IDLE: q_pop_o = take;
      BS_CMP: begin
        mem_we = hit || empty_slot;
        mem_wd.valid  = 1'b1;
        mem_wd.key    = cur_q.key;
        mem_wd.stream = base_stream;
        mem_wd.pkts   = new_pkts;
        mem_wd.cstate = new_st;
        mem_wd.flags  = new_fg;
      end
      default: q_pop_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata_q <= mem[addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= BS_CLEAR;
      sweep_q       <= '0;
      next_stream_q <= '0;
      res_valid_q   <= 1'b0;
      probes_q      <= '0;
    end else begin
      state_q <= state_d;
      if (res_valid_q && out_ready_i) res_valid_q <= 1'b0;
      if (state_q == BS_CLEAR) sweep_q <= sweep_q + 1'b1;
      case (state_q)
        BS_IDLE: begin
          if (take) begin
            probes_q <= '0;
            if (qitem_i.op == OP_CLEAR) begin
              next_stream_q <= '0;
              sweep_q       <= '0;
            end
            if (qitem_i.op != OP_PKT) res_valid_q <= 1'b1;
          end
        end
        BS_CMP: begin
          probes_q <= probes_q + 1'b1;
          if (hit || empty_slot || last_probe) res_valid_q <= 1'b1;
          if (!hit && empty_slot) next_stream_q <= next_stream_q + 32'd1;
        end
        default: probes_q <= probes_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == BS_IDLE && take) begin
      cur_q  <= qitem_i;
      addr_q <= hash;
      res_q  <= '0;
    end else if (state_q == BS_CMP) begin
      if (hit || empty_slot) begin
        res_q.status        <= hit ? STAT_EXIST : STAT_NEW;
        res_q.stream_number <= base_stream;
        res_q.conn_state    <= new_st;
        res_q.flow_packets  <= new_pkts;
        res_q.app_label     <= label;
      end else if (last_probe) begin
        res_q <= '{status: STAT_FULL, default: '0};
      end else begin
        addr_q <= addr_inc;
      end
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_item_o  = res_q;

endmodule
`default_nettype wire

[rtl/flow_table_tcp_tracker_top.sv]
// Top level of the flow table TCP tracker.
//  channel | signals                        | direction
//  in      | in_valid_i, in_ready_o, in_item_i   | header or clear command into block
//  out     | out_valid_o, out_ready_i, out_item_o | one result per transfer in
// Ignored and clear items give their result in the cycle after they leave the queue.
// A packet is looked up by linear probing of the hashed table: each probe reads
// an entry (BS_RD) and compares it (BS_CMP); a full table is probed at every entry.
// A clear item, and reset, sweep the table, writing every entry invalid.
// The two-entry queue keeps accepting while the engine works or the output
// stalls, until it holds two items.
`default_nettype none
module flow_table_tcp_tracker_top #(
  parameter int unsigned FLOW_ENTRIES = fttt_pkg::FlowEntriesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fttt_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output fttt_pkg::out_item_t out_item_o
);
  import fttt_pkg::*;

  qitem_t fq, bq;
  qctl_t  qctl, qstat;
  logic   pop;

  fttt_front u_front (
    .in_item_i (in_item_i),
    .qitem_o   (fq)
  );

  assign qctl.push  = in_valid_i && !qstat.full;
  assign qctl.pop   = pop;
  assign qctl.full  = 1'b0;
  assign qctl.empty = 1'b0;
  assign in_ready_o = !qstat.full;

  fttt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wdata_i (fq),
    .rdata_o (bq),
    .ctl_i   (qctl),
    .stat_o  (qstat)
  );

  fttt_back #(.FLOW_ENTRIES(FLOW_ENTRIES)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .qitem_i     (bq),
    .q_empty_i   (qstat.empty),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
`default_nettype wire

[rtl/fttt_checker.sv]
// Port-level checks for the flow table TCP tracker, bound to the top level.
`default_nettype none
module fttt_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input fttt_pkg::out_item_t out_item_o
);
  import fttt_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  a_ign_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == STAT_IGNORE |->
      out_item_o.stream_number == 32'd0 && out_item_o.flow_packets == 32'd0 &&
      out_item_o.conn_state == CS_NONE && out_item_o.app_label == LBL_NONE)
    else $error("ignored result carries data");

  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == STAT_FULL |->
      out_item_o.stream_number == 32'd0 && out_item_o.flow_packets == 32'd0)
    else $error("dropped result carries data");

  a_new_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == STAT_NEW |-> out_item_o.flow_packets == 32'd1)
    else $error("new flow packet count not one");

endmodule

bind flow_table_tcp_tracker_top fttt_checker u_fttt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);
`default_nettype wire

[sim/testbench.sv]
// Testbench for the flow table TCP tracker: directed and random header traffic.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import fttt_pkg::*;

  localparam int unsigned Entries = FlowEntriesDef;
  localparam int unsigned Watchdog = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_item_t out_item_o;

  flow_table_tcp_tracker_top u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_item_o(out_item_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // flow table shadow
  logic        tbl_valid [Entries];
  key_t        tbl_key   [Entries];
  logic [31:0] tbl_stream[Entries];
  logic [31:0] tbl_pkts  [Entries];
  logic [2:0]  tbl_cs    [Entries];
  logic [2:0]  tbl_flags [Entries];
  logic [31:0] next_stream;

  out_item_t expected_results[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_recv = 1'b0;
  int idle_cycles = 0;

  function automatic logic [63:0] v4_word(logic [63:0] a);
    return {a[7:0], a[15:8], a[23:16], a[31:24], 32'h0};
  endfunction

  function automatic out_item_t track_packet(in_item_t it);
    out_item_t r;
    key_t k;
    logic [63:0] t;
    logic [15:0] p1, p2, tp;
    logic v6;
    int idx, free_idx;
    bit found, have_free;
    r = '0;
    k = '0;
    v6 = 1'b0;
    p1 = it.src_l4_port;
    p2 = it.dst_port;
    found = 0;
    have_free = 0;
    idx = 0;
    free_idx = 0;
    if (it.cmd) begin
      for (int i = 0; i < Entries; i++) tbl_valid[i] = 1'b0;
      next_stream = '0;
      return r;
    end
    if (it.l4_kind != L4_TCP && it.l4_kind != L4_UDP) return r;
    if (it.ip_version == IPV_4 || it.ip_version == IPV_6) begin
      if (it.ip_version == IPV_4) begin
        k.a_hi = v4_word(it.src_addr_lo);
        k.b_hi = v4_word(it.dst_addr_lo);
      end else begin
        v6 = 1'b1;
        k.a_hi = it.src_addr_hi; k.a_lo = it.src_addr_lo;
        k.b_hi = it.dst_addr_hi; k.b_lo = it.dst_addr_lo;
      end
      if ({k.a_hi, k.a_lo, p1} > {k.b_hi, k.b_lo, p2}) begin
        t = k.a_hi; k.a_hi = k.b_hi; k.b_hi = t;
        t = k.a_lo; k.a_lo = k.b_lo; k.b_lo = t;
        tp = p1; p1 = p2; p2 = tp;
      end
    end
    k.meta = {it.l4_kind, v6, p1, p2};
    for (int i = 0; i < Entries; i++) begin
      if (tbl_valid[i]) begin
        if (!found && tbl_key[i] == k) begin
          found = 1; idx = i;
        end
      end else if (!have_free) begin
        have_free = 1; free_idx = i;
      end
    end
    if (found) begin
      r.status = STAT_EXIST;
    end else if (have_free) begin
      idx = free_idx;
      tbl_valid[idx] = 1'b1;
      tbl_key[idx] = k;
      tbl_stream[idx] = next_stream;
      next_stream++;
      tbl_pkts[idx] = '0;
      tbl_cs[idx] = CS_NONE;
      tbl_flags[idx] = '0;
      r.status = STAT_NEW;
    end else begin
      r.status = STAT_FULL;
      return r;
    end
    if (tbl_pkts[idx] != CNT_MAX) tbl_pkts[idx]++;
    if (it.l4_kind == L4_TCP) begin
      if (it.tcp_flags[TF_SYN]) begin
        if (it.tcp_flags[TF_ACK]) begin
          tbl_flags[idx][FF_SYNACK] = 1'b1;
          if (tbl_cs[idx] == CS_SYN_SENT) tbl_cs[idx] = CS_SYN_RCVD;
        end else begin
          tbl_flags[idx][FF_SYN] = 1'b1;
          tbl_cs[idx] = CS_SYN_SENT;
        end
      end else if (it.tcp_flags[TF_ACK]) begin
        if (tbl_flags[idx][FF_SYN] && tbl_flags[idx][FF_SYNACK] && tbl_cs[idx] == CS_SYN_RCVD)
          tbl_cs[idx] = CS_ESTABLISHED;
      end else if (it.tcp_flags[TF_FIN]) begin
        tbl_cs[idx] = CS_FIN_WAIT;
      end else if (it.tcp_flags[TF_RST]) begin
        tbl_cs[idx] = CS_CLOSED;
      end
    end else if (it.quic_kind == QK_LONG) begin
      tbl_flags[idx][FF_QUIC] = 1'b1;
      r.app_label = LBL_QUIC;
    end else if (it.quic_kind == QK_SHORT) begin
      r.app_label = tbl_flags[idx][FF_QUIC] ? LBL_PROT : LBL_UDP;
    end
    r.stream_number = tbl_stream[idx];
    r.conn_state = tbl_cs[idx];
    r.flow_packets = tbl_pkts[idx];
    return r;
  endfunction

  // valid drops only when the sender idles or drains
  task automatic send_item(in_item_t it);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_results.push_back(track_packet(it));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() > 0) @(posedge clk_i);
  endtask

  // random address pools keep flows recurring
  logic [63:0] pool_hi[8];
  logic [63:0] pool_lo[8];
  logic [15:0] pool_port[8];

  function automatic in_item_t rand_header(bit wellformed);
    in_item_t it;
    it = '0;
    it.l4_kind = wellformed ? 2'($urandom_range(1, 2)) : 2'($urandom_range(0, 3));
    it.ip_version = wellformed ? 2'($urandom_range(1, 2)) : 2'($urandom_range(0, 3));
    it.src_addr_hi = wellformed ? pool_hi[$urandom_range(7)] : {$urandom, $urandom};
    it.src_addr_lo = wellformed ? pool_lo[$urandom_range(7)] : {$urandom, $urandom};
    it.dst_addr_hi = wellformed ? pool_hi[$urandom_range(7)] : {$urandom, $urandom};
    it.dst_addr_lo = wellformed ? pool_lo[$urandom_range(7)] : {$urandom, $urandom};
    it.src_l4_port = wellformed ? pool_port[$urandom_range(3)] : 16'($urandom);
    it.dst_port = wellformed ? pool_port[$urandom_range(3)] : 16'($urandom);
    it.tcp_flags = 5'($urandom);
    it.quic_kind = 2'($urandom_range(0, 3));
    return it;
  endfunction

  task automatic run_random(int n);
    in_item_t it;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(199) == 0) begin
        it = '0;
        it.cmd = 1'b1;
        it.l4_kind = 2'($urandom);
      end else begin
        it = rand_header($urandom_range(9) < 8);
      end
      send_item(it);
    end
  endtask

  task automatic test_directed();
    in_item_t it;
    logic [4:0] fl[6];
    fl = '{5'b00010, 5'b10010, 5'b10000, 5'b01000, 5'b00001, 5'b00100};
    it = '0;
    it.l4_kind = L4_TCP;
    it.ip_version = IPV_4;
    it.src_addr_lo = 64'hFFFF_FFFF_0A00_0001;
    it.dst_addr_lo = 64'h0000_0000_0A00_0002;
    it.src_l4_port = 16'hFFFF;
    it.dst_port = 16'd80;
    foreach (fl[i]) begin
      it.tcp_flags = fl[i];
      send_item(it);
      {it.src_addr_lo, it.dst_addr_lo} = {it.dst_addr_lo, it.src_addr_lo};
      {it.src_l4_port, it.dst_port} = {it.dst_port, it.src_l4_port};
    end
    it.tcp_flags = 5'h1F;
    send_item(it);
    // IPv6, equal addresses, port tie break
    it.ip_version = IPV_6;
    it.src_addr_hi = '1; it.src_addr_lo = '1;
    it.dst_addr_hi = '1; it.dst_addr_lo = '1;
    it.src_l4_port = 16'd9; it.dst_port = 16'd0;
    send_item(it);
    // UDP / QUIC labels
    it.l4_kind = L4_UDP;
    it.quic_kind = QK_SHORT; send_item(it);
    it.quic_kind = QK_LONG;  send_item(it);
    it.quic_kind = QK_SHORT; send_item(it);
    it.quic_kind = 2'd3;     send_item(it);
    it.quic_kind = 2'd0;     send_item(it);
    // no IP version, ignored protocol
    it.ip_version = 2'd0; send_item(it);
    it.ip_version = 2'd3; send_item(it);
    it.l4_kind = 2'd0; send_item(it);
    it.l4_kind = 2'd3; send_item(it);
    it = '0;
    it.cmd = 1'b1; it.l4_kind = L4_TCP;
    send_item(it);
    drain();
  endtask

  task automatic test_table_full();
    in_item_t it;
    it = '0;
    it.l4_kind = L4_UDP;
    it.ip_version = IPV_4;
    for (int i = 0; i < Entries + 4; i++) begin
      it.src_l4_port = 16'(i);
      send_item(it);
    end
    it.src_l4_port = 16'd3;
    send_item(it);
    drain();
    it = '0;
    it.cmd = 1'b1;
    send_item(it);
    drain();
  endtask

  task automatic test_backpressure();
    in_item_t it;
    hold_recv = 1'b1;
    for (int i = 0; i < 8; i++) begin
      it = rand_header(1'b1);
      send_item(it);
    end
    drain();
  endtask

  task automatic test_random();
    send_idle_pct = 0;  recv_stall_pct = 0;  run_random(328);
    send_idle_pct = 54; recv_stall_pct = 0;  run_random(328);
    drain();
    send_idle_pct = 0;  recv_stall_pct = 54; run_random(328);
    send_idle_pct = 14; recv_stall_pct = 14; run_random(328);
  endtask

  // result checker
  always @(posedge clk_i) begin
    out_item_t e;
    if (out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result %p", $time, out_item_o);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_item_o.status !== e.status)
          $display("%0t status exp %0d got %0d", $time, e.status, out_item_o.status);
        if (out_item_o.stream_number !== e.stream_number)
          $display("%0t stream exp %0d got %0d", $time, e.stream_number,
                   out_item_o.stream_number);
        if (out_item_o.conn_state !== e.conn_state)
          $display("%0t conn_state exp %0d got %0d", $time, e.conn_state,
                   out_item_o.conn_state);
        if (out_item_o.flow_packets !== e.flow_packets)
          $display("%0t packets exp %0d got %0d", $time, e.flow_packets,
                   out_item_o.flow_packets);
        if (out_item_o.app_label !== e.app_label)
          $display("%0t label exp %0d got %0d", $time, e.app_label, out_item_o.app_label);
        if (out_item_o !== e) errors++;
      end
    end
  end

  // receiver ready, with a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_recv) begin
      out_ready_i <= 1'b0;
      repeat (300) @(posedge clk_i);
      hold_recv = 1'b0;
    end else begin
      out_ready_i <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog on cycles without transfers
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > Watchdog) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 8; i++) begin
      pool_hi[i] = (i == 0) ? '0 : ((i == 1) ? '1 : {$urandom, $urandom});
      pool_lo[i] = (i == 0) ? '0 : ((i == 1) ? '1 : {$urandom, $urandom});
      pool_port[i] = 16'($urandom);
    end
    for (int i = 0; i < Entries; i++) tbl_valid[i] = 1'b0;
    next_stream = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_table_full();
    test_backpressure();
    test_random();
    drain();
    repeat (2 * Entries + 20) @(posedge clk_i);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
